>>> rtl/drls_pkg.sv
`timescale 1ns / 1ps

package drls_pkg;

  localparam int BLOCK_COEFFS = 64;
  localparam int POS_W        = (BLOCK_COEFFS > 2) ? $clog2(BLOCK_COEFFS) : 1;
  localparam int RUN_W        = 6;
  localparam int CMD_DEPTH    = 4;
  localparam int CMD_PTR_W    = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W    = $clog2(CMD_DEPTH + 1);

  localparam logic [POS_W-1:0] POS_LAST    = POS_W'(BLOCK_COEFFS - 1);
  localparam logic [RUN_W-1:0] RUN_CAP     = '1;
  localparam logic [CMD_CNT_W-1:0] CMD_FULL = CMD_CNT_W'(CMD_DEPTH);

  typedef enum logic [1:0] {
    KIND_DC  = 2'd0,
    KIND_AC  = 2'd1,
    KIND_ZRL = 2'd2,
    KIND_EOB = 2'd3
  } kind_e;

  typedef struct packed {
    logic signed [11:0] coeff;
    logic               restart_predictor;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [3:0]  run;
    logic [3:0]  size;
    logic [11:0] amplitude_bits;
    logic        last;
  } out_item_t;

  // One command per item that yields results: leading ZRL count, then one symbol.
  typedef struct packed {
    logic [1:0]  zrl_count;
    kind_e       kind;
    logic [3:0]  run;
    logic [3:0]  size;
    logic [11:0] amplitude_bits;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } cmd_wr_t;

  // Bit length of the magnitude of a 13-bit signed value.
  function automatic logic [3:0] mag_size(logic signed [12:0] v);
    logic [12:0] m;
    logic [3:0]  s;
    m = v[12] ? 13'(-v) : 13'(v);
    s = '0;
    for (int i = 0; i < 13; i++) begin
      if (m[i]) begin
        s = 4'(i + 1);
      end
    end
    return s;
  endfunction

  // Low size bits of the value, or of value minus one when negative.
  function automatic logic [11:0] amp_bits(logic signed [12:0] v, logic [3:0] size);
    logic [12:0] u;
    logic [12:0] mask;
    u    = v[12] ? 13'(v - 13'sd1) : 13'(v);
    mask = (13'd1 << size) - 13'd1;
    return u[11:0] & mask[11:0];
  endfunction

endpackage

>>> rtl/drls_front.sv
`timescale 1ns / 1ps

module drls_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  drls_pkg::in_item_t in_item_i,
  output drls_pkg::cmd_wr_t  cmd_wr_o
);
  import drls_pkg::*;

  logic [POS_W-1:0]  pos_q, pos_d;
  logic [RUN_W-1:0]  zero_run_q, zero_run_d;
  logic signed [11:0] prev_dc_q, prev_dc_d;

  logic               final_pos;
  logic signed [12:0] dc_pred;
  logic signed [12:0] value;
  logic [3:0]         value_size;

  assign final_pos = (pos_q == POS_LAST);
  assign dc_pred   = in_item_i.restart_predictor ? 13'sd0 : 13'(prev_dc_q);
  // DC codes the difference to the predictor; AC codes the coefficient itself.
  assign value      = (pos_q == '0) ? 13'(in_item_i.coeff) - dc_pred
                                    : 13'(in_item_i.coeff);
  assign value_size = mag_size(value);

  always_comb begin
    pos_d      = pos_q;
    zero_run_d = zero_run_q;
    prev_dc_d  = prev_dc_q;
    cmd_wr_o.push               = 1'b0;
    cmd_wr_o.cmd.zrl_count      = '0;
    cmd_wr_o.cmd.kind           = KIND_DC;
    cmd_wr_o.cmd.run            = '0;
    cmd_wr_o.cmd.size           = value_size;
    cmd_wr_o.cmd.amplitude_bits = amp_bits(value, value_size);
    if (accept_i) begin
      if (pos_q == '0) begin
        cmd_wr_o.push = 1'b1;
        prev_dc_d     = in_item_i.coeff;
        zero_run_d    = '0;
      end else if (in_item_i.coeff == '0) begin
        if (zero_run_q != RUN_CAP) begin
          zero_run_d = zero_run_q + 1'b1;
        end
        if (final_pos) begin
          cmd_wr_o.push               = 1'b1;
          cmd_wr_o.cmd.kind           = KIND_EOB;
          cmd_wr_o.cmd.size           = '0;
          cmd_wr_o.cmd.amplitude_bits = '0;
        end
      end else begin
        cmd_wr_o.push          = 1'b1;
        cmd_wr_o.cmd.kind      = KIND_AC;
        cmd_wr_o.cmd.zrl_count = zero_run_q[5:4];
        cmd_wr_o.cmd.run       = zero_run_q[3:0];
        zero_run_d             = '0;
      end
      if (final_pos) begin
        pos_d      = '0;
        zero_run_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      zero_run_q <= '0;
      prev_dc_q  <= '0;
    end else begin
      pos_q      <= pos_d;
      zero_run_q <= zero_run_d;
      prev_dc_q  <= prev_dc_d;
    end
  end

endmodule

>>> rtl/drls_fifo.sv
`timescale 1ns / 1ps

module drls_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  drls_pkg::cmd_wr_t cmd_wr_i,
  input  logic              rd_i,
  output logic              valid_o,
  output logic              full_o,
  output drls_pkg::cmd_t    cmd_o
);
  import drls_pkg::*;

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] count_q;
  logic                 do_rd;

  assign valid_o = (count_q != '0);
  assign full_o  = (count_q == CMD_FULL);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (cmd_wr_i.push) begin
      mem_q[wr_ptr_q] <= cmd_wr_i.cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (cmd_wr_i.push) begin
        wr_ptr_q <= CMD_PTR_W'((32'(wr_ptr_q) + 1) % CMD_DEPTH);
      end
      if (do_rd) begin
        rd_ptr_q <= CMD_PTR_W'((32'(rd_ptr_q) + 1) % CMD_DEPTH);
      end
      count_q <= count_q + CMD_CNT_W'(cmd_wr_i.push) - CMD_CNT_W'(do_rd);
    end
  end

endmodule

>>> rtl/drls_back.sv
`timescale 1ns / 1ps

module drls_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  drls_pkg::cmd_t      cmd_i,
  output logic                cmd_rd_o,
  output logic                empty_o,
  input  logic                pop_i,
  output drls_pkg::out_item_t out_item_o
);
  import drls_pkg::*;

  cmd_t       cur_q;
  logic       valid_q;
  logic [1:0] zrl_left_q;
  logic       take;
  logic       cmd_done;

  assign take     = pop_i && valid_q;
  assign cmd_done = !valid_q || (take && zrl_left_q == '0);
  assign cmd_rd_o = cmd_valid_i && cmd_done;
  assign empty_o  = !valid_q;

  always_comb begin
    if (zrl_left_q != '0) begin
      out_item_o.kind           = KIND_ZRL;
      out_item_o.run            = '0;
      out_item_o.size           = '0;
      out_item_o.amplitude_bits = '0;
      out_item_o.last           = 1'b0;
    end else begin
      out_item_o.kind           = cur_q.kind;
      out_item_o.run            = cur_q.run;
      out_item_o.size           = cur_q.size;
      out_item_o.amplitude_bits = cur_q.amplitude_bits;
      out_item_o.last           = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_rd_o) begin
      cur_q <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      zrl_left_q <= '0;
    end else if (cmd_rd_o) begin
      valid_q    <= 1'b1;
      zrl_left_q <= cmd_i.zrl_count;
    end else if (take) begin
      if (zrl_left_q != '0) begin
        zrl_left_q <= zrl_left_q - 1'b1;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/dct_coeff_run_length_symbolizer.sv
`timescale 1ns / 1ps

// Run-length symbolizer for quantized DCT coefficients in zigzag order, one
// coefficient per input transfer and BLOCK_COEFFS coefficients per block, the
// first of each block being DC. Each block yields one DC symbol (size and
// amplitude bits of the difference to the previous DC, or to zero when
// restart_predictor is set), then for each nonzero AC coefficient up to three
// ZRL symbols and a run/size pair, and an EOB when the block ends in zeros.
// The last field marks the final symbol caused by one coefficient.
// Rate: one coefficient is taken every cycle while full is low. An item that
// yields k ZRL symbols holds the result side for k + 1 symbols, one symbol per
// pop; the four-entry command queue between classifier and symbol expander
// soaks up these bursts, and full rises only when that queue is full. The
// first symbol of an accepted coefficient passes through the command queue and
// then the expander's command register before it reaches the result ports.

module dct_coeff_run_length_symbolizer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  drls_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output drls_pkg::out_item_t out_item_o
);
  import drls_pkg::*;

  cmd_wr_t cmd_wr;
  cmd_t    cmd_head;
  logic    cmd_valid;
  logic    cmd_rd;
  logic    accept;

  // Transfer in whenever the command queue has room.
  assign accept = push && !full;

  // Front: track block position, zero run and DC predictor; classify.
  drls_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_item_i (in_item_i),
    .cmd_wr_o  (cmd_wr)
  );

  // Decouple the classifier from the symbol expander.
  drls_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_wr_i (cmd_wr),
    .rd_i     (cmd_rd),
    .valid_o  (cmd_valid),
    .full_o   (full),
    .cmd_o    (cmd_head)
  );

  // Back: expand each command into ZRL symbols and its final symbol.
  drls_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .cmd_rd_o    (cmd_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .out_item_o  (out_item_o)
  );

  // A ZRL is never the last symbol of its command: a symbol must follow.
  a_zrl_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !empty && out_item_o.kind == KIND_ZRL |=> !empty)
    else $error("ZRL transfer not followed by a symbol");

  // A full queue means the expander already holds a command.
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("command queue full while result side empty");

  // ZRL never carries last; every other kind always does.
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_item_o.last == (out_item_o.kind != KIND_ZRL)))
    else $error("last flag inconsistent with symbol kind");

endmodule
